// ----- design/kms_pkg.sv -----
// Shared types and constants for the key matrix scanner.
package kms_pkg;

   localparam int unsigned COUNT_W = 16;
   localparam int unsigned COLS    = 8;
   localparam int unsigned CODE_W  = 7;
   localparam int unsigned ROW_W   = 4;

   localparam logic [COUNT_W-1:0] DELAY_RST  = 16'd500;
   localparam logic [COUNT_W-1:0] PERIOD_RST = 16'd64;

   // register indexes on the csr port
   localparam logic [1:0] CSR_DELAY  = 2'd0;
   localparam logic [1:0] CSR_PERIOD = 2'd1;

   // request opcodes
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_SET  = 1'b1;

   // result kinds
   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // one scan's worth of events handed to the emitter
   typedef struct packed {
      logic              rep;
      logic [CODE_W-1:0] rep_code;
      logic [COLS-1:0]   rel;
      logic [COLS-1:0]   prs;
      logic [ROW_W-1:0]  row;
      logic [ROW_W-1:0]  next_row;
   } kms_job_type;

endpackage

// ----- design/kms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kms_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/kms_emit.sv -----
// Event emitter: serialises repeat, release, press and done words.
module kms_emit
   import kms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  kms_job_type job,
   output logic        busy,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [6:0] key_code, [10:7] next_row, [15:11] zero
   output logic [1:0]  rsp_tuser,   // [0] item_kind, [1] released
   output logic        rsp_tlast
);

   logic              rep_ff, rep_in;
   logic [CODE_W-1:0] rep_code_ff, rep_code_in;
   logic [COLS-1:0]   rel_ff, rel_in;
   logic [COLS-1:0]   prs_ff, prs_in;
   logic              done_ff, done_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  nrow_ff, nrow_in;

   logic              vld_ff, vld_in;
   logic              kind_ff, kind_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              relf_ff, relf_in;
   logic [ROW_W-1:0]  onrow_ff, onrow_in;
   logic              last_ff, last_in;

   logic              slot_free;

   function automatic logic [2:0] low_bit(input logic [COLS-1:0] m);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = COLS - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

   assign busy      = rep_ff | (|rel_ff) | (|prs_ff) | done_ff;
   assign slot_free = !vld_ff || rsp_tready;

   always_comb begin
      rep_in      = rep_ff;
      rep_code_in = rep_code_ff;
      rel_in      = rel_ff;
      prs_in      = prs_ff;
      done_in     = done_ff;
      row_in      = row_ff;
      nrow_in     = nrow_ff;
      vld_in      = vld_ff;
      kind_in     = kind_ff;
      code_in     = code_ff;
      relf_in     = relf_ff;
      onrow_in    = onrow_ff;
      last_in     = last_ff;

      if (slot_free) begin
         vld_in = busy;
         if (rep_ff) begin
            kind_in  = KIND_KEY;
            code_in  = rep_code_ff;
            relf_in  = 1'b0;
            onrow_in = '0;
            last_in  = 1'b0;
            rep_in   = 1'b0;
         end else if (|rel_ff) begin
            kind_in  = KIND_KEY;
            code_in  = {row_ff, low_bit(rel_ff)};
            relf_in  = 1'b1;
            onrow_in = '0;
            last_in  = 1'b0;
            rel_in   = rel_ff & (rel_ff - 1'b1);
         end else if (|prs_ff) begin
            kind_in  = KIND_KEY;
            code_in  = {row_ff, low_bit(prs_ff)};
            relf_in  = 1'b0;
            onrow_in = '0;
            last_in  = 1'b0;
            prs_in   = prs_ff & (prs_ff - 1'b1);
         end else if (done_ff) begin
            kind_in  = KIND_DONE;
            code_in  = '0;
            relf_in  = 1'b0;
            onrow_in = nrow_ff;
            last_in  = 1'b1;
            done_in  = 1'b0;
         end
      end

      // top only loads when idle
      if (load) begin
         rep_in      = job.rep;
         rep_code_in = job.rep_code;
         rel_in      = job.rel;
         prs_in      = job.prs;
         row_in      = job.row;
         nrow_in     = job.next_row;
         done_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_ff  <= 1'b0;
         rel_ff  <= '0;
         prs_ff  <= '0;
         done_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         rep_ff  <= rep_in;
         rel_ff  <= rel_in;
         prs_ff  <= prs_in;
         done_ff <= done_in;
         vld_ff  <= vld_in;
      end
      rep_code_ff <= rep_code_in;
      row_ff      <= row_in;
      nrow_ff     <= nrow_in;
      kind_ff     <= kind_in;
      code_ff     <= code_in;
      relf_ff     <= relf_in;
      onrow_ff    <= onrow_in;
      last_ff     <= last_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {5'b0, onrow_ff, code_ff};
   assign rsp_tuser  = {relf_ff, kind_ff};
   assign rsp_tlast  = last_ff;

endmodule

// ----- design/key_matrix_scan_autorepeat.sv -----
// Key matrix scanner top level: row store RAM, repeat counter and sequencer.
// Scan word: accepted, the row store read is issued, the lookup state writes the row back and
//   loads the emitter, then one result word per cycle while rsp_tready is high (up to ten).
// Set-repeat word: handled while idle, no results. Rate set by the serial emitter.
// Reset: synchronous; row valid bits clear at once (invalid rows read as zero),
//   row 0, repeat disarmed, count 500, delay 500, period 64.
module key_matrix_scan_autorepeat
   import kms_pkg::*;
#(
   parameter int unsigned ROWS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] column_bits, [14:8] repeat_key, [15] repeat_on
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [6:0] key_code, [10:7] next_row, [15:11] zero
   output logic [1:0]  rsp_tuser,   // [0] item_kind, [1] released
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned RowW = $clog2(ROWS);

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type         state_ff, state_in;
   logic [RowW-1:0]   row_ff, row_in;
   logic [ROWS-1:0]   row_vld_ff, row_vld_in;
   logic              armed_ff, armed_in;
   logic [CODE_W-1:0] rcode_ff, rcode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] delay_ff, delay_in;
   logic [COUNT_W-1:0] period_ff, period_in;
   logic              rep_hit_ff, rep_hit_in;
   logic [COLS-1:0]   cols_ff, cols_in;

   logic              accept;
   logic              busy;
   logic              load;
   kms_job_type       job;
   logic [COLS-1:0]   rd_data;
   logic [COLS-1:0]   old_cols;
   logic [COLS-1:0]   chg;
   logic [RowW-1:0]   next_row;
   logic [COUNT_W-1:0] count_dec;
   logic [COLS-1:0]   in_cols;
   logic [CODE_W-1:0] in_key;
   logic              in_on;
   logic              set_change;

   assign in_cols = req_tdata[7:0];
   assign in_key  = req_tdata[14:8];
   assign in_on   = req_tdata[15];

   // one word in flight: take a new one only when the emitter has drained
   assign req_tready = (state_ff == ST_IDLE) && !busy;
   assign accept     = req_tvalid && req_tready;

   assign count_dec  = count_ff - 1'b1;
   assign set_change = (in_on != armed_ff) || (in_on && (in_key != rcode_ff));

   // row store read is issued at accept; the write-back lands in the lookup
   // cycle, before the row pointer moves on; no read is issued then, so read and write never overlap
   assign old_cols = row_vld_ff[row_ff] ? rd_data : '0;
   assign chg      = old_cols ^ cols_ff;
   assign next_row = (row_ff == RowW'(ROWS - 1)) ? '0 : row_ff + 1'b1;
   assign load     = (state_ff == ST_LOOKUP);

   always_comb begin
      job.rep      = rep_hit_ff;
      job.rep_code = rcode_ff;
      job.rel      = old_cols & chg;
      job.prs      = cols_ff & chg;
      job.row      = ROW_W'(row_ff);
      job.next_row = ROW_W'(next_row);
   end

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      row_vld_in = row_vld_ff;
      armed_in   = armed_ff;
      rcode_in   = rcode_ff;
      count_in   = count_ff;
      delay_in   = delay_ff;
      period_in  = period_ff;
      rep_hit_in = rep_hit_ff;
      cols_in    = cols_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_SET) begin
                  if (set_change) begin
                     armed_in = in_on;
                     rcode_in = in_on ? in_key : '0;
                     count_in = delay_ff;
                  end
               end else begin
                  cols_in    = in_cols;
                  rep_hit_in = 1'b0;
                  if (armed_ff) begin
                     if (count_dec == '0) begin
                        count_in   = period_ff;
                        rep_hit_in = 1'b1;
                     end else begin
                        count_in = count_dec;
                     end
                  end
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            row_vld_in[row_ff] = 1'b1;
            row_in             = next_row;
            state_in           = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // register writes must arrive only while idle; the block itself does not enforce it
      if (csr_we) begin
         case (csr_addr)
            CSR_DELAY: begin
               delay_in = csr_wdata;
               count_in = csr_wdata;
            end
            CSR_PERIOD: period_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_ff     <= '0;
         row_vld_ff <= '0;
         armed_ff   <= 1'b0;
         rcode_ff   <= '0;
         count_ff   <= DELAY_RST;
         delay_ff   <= DELAY_RST;
         period_ff  <= PERIOD_RST;
         rep_hit_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         row_vld_ff <= row_vld_in;
         armed_ff   <= armed_in;
         rcode_ff   <= rcode_in;
         count_ff   <= count_in;
         delay_ff   <= delay_in;
         period_ff  <= period_in;
         rep_hit_ff <= rep_hit_in;
      end
      cols_ff <= cols_in;
   end

   kms_ram #(
      .WIDTH (COLS),
      .DEPTH (ROWS)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (load),
      .wr_addr (row_ff),
      .wr_data (cols_ff),
      .rd_en   (accept),
      .rd_addr (row_ff),
      .rd_data (rd_data)
   );

   kms_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .job        (job),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- verif/testbench.sv -----
// Self-checking bench for the key matrix scanner: row events, auto-repeat and done markers.
module testbench
   import kms_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_ROWS   = 16;
   localparam int unsigned SETTLE     = 16;    // a scan word gives ten results at most
   localparam int unsigned LONG_HOLD  = 400;   // receiver back-off, long enough to fill the block
   localparam int unsigned IDLE_LIMIT = 4000;  // cycles with no handshake at all
   localparam int unsigned PHASE_LEN  = 26;

   // register slots above the two real ones; writes there must be ignored
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   // one request word as the block sees it
   typedef struct packed {
      logic              op;
      logic [COLS-1:0]   cols;
      logic [CODE_W-1:0] key;
      logic              on;
   } scan_word_type;

   // one result word
   typedef struct packed {
      logic              kind;
      logic [CODE_W-1:0] code;
      logic              rel;
      logic [ROW_W-1:0]  nrow;
      logic              last;
   } key_event_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = OP_SCAN;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = CSR_DELAY;
   logic [15:0] csr_wdata  = '0;

   key_matrix_scan_autorepeat #(.ROWS(NUM_ROWS)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Predictor: own copy of the scanner state and registers
   // ---------------------------------------------------------------
   logic [COLS-1:0]    seen_cols [NUM_ROWS];
   logic [ROW_W-1:0]   scan_row;
   logic               rep_armed;
   logic [CODE_W-1:0]  rep_code;
   logic [COUNT_W-1:0] rep_count;
   logic [COUNT_W-1:0] rep_delay;
   logic [COUNT_W-1:0] rep_period;

   key_event_type due_keys [$];   // results still owed by the block
   int            errors = 0;

   function automatic void matrix_clear();
      foreach (seen_cols[r]) seen_cols[r] = '0;
      scan_row   = '0;
      rep_armed  = 1'b0;
      rep_code   = '0;
      rep_delay  = DELAY_RST;
      rep_period = PERIOD_RST;
      rep_count  = DELAY_RST;
   endfunction

   function automatic void owe(input logic kind, input logic [CODE_W-1:0] code,
                               input logic rel, input logic [ROW_W-1:0] nrow,
                               input logic last);
      key_event_type e;
      e.kind = kind;
      e.code = code;
      e.rel  = rel;
      e.nrow = nrow;
      e.last = last;
      due_keys.push_back(e);
   endfunction

   function automatic void matrix_predict(input scan_word_type w);
      logic [COLS-1:0]  prev;
      logic [COLS-1:0]  gone;
      logic [COLS-1:0]  down;
      logic [ROW_W-1:0] nxt;
      if (w.op == OP_SET) begin
         // a change is a new armed state, or a new key while staying armed
         if (w.on != rep_armed || (w.on && w.key != rep_code)) begin
            rep_armed = w.on;
            rep_code  = w.on ? w.key : '0;
            rep_count = rep_delay;
         end
         return;
      end
      if (rep_armed) begin
         rep_count = rep_count - 1'b1;   // wraps from zero
         if (rep_count == '0) begin
            rep_count = rep_period;
            owe(KIND_KEY, rep_code, 1'b0, '0, 1'b0);
         end
      end
      prev = seen_cols[scan_row];
      gone = prev & ~w.cols;
      down = w.cols & ~prev;
      for (int c = 0; c < COLS; c++)
         if (gone[c]) owe(KIND_KEY, {scan_row, 3'(c)}, 1'b1, '0, 1'b0);
      for (int c = 0; c < COLS; c++)
         if (down[c]) owe(KIND_KEY, {scan_row, 3'(c)}, 1'b0, '0, 1'b0);
      seen_cols[scan_row] = w.cols;
      nxt      = ROW_W'((int'(scan_row) + 1) % NUM_ROWS);
      scan_row = nxt;
      owe(KIND_DONE, '0, 1'b0, nxt, 1'b1);
   endfunction

   // ---------------------------------------------------------------
   // Driver: bursts of words with random gaps between them
   // ---------------------------------------------------------------
   scan_word_type scan_words [$];
   scan_word_type on_bus;
   int            burst_left = 0;
   int            gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // word on the bus taken at this edge: predict its results now
         if (req_tvalid && req_tready) matrix_predict(on_bus);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (scan_words.size() > 0) begin
               on_bus = scan_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {on_bus.on, on_bus.key, on_bus.cols};
               req_tuser  <= on_bus.op;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst; a quarter of them run straight on with no gap
                  burst_left = $urandom_range(0, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: stall pattern changes segment by segment, plus one long hold
   // ---------------------------------------------------------------
   logic long_hold_go = 1'b0;
   logic hold_done    = 1'b0;
   int   hold_left    = 0;
   int   seg_left     = 0;
   int   ready_mode   = 0;
   int   tick         = 0;

   always @(posedge clock) begin
      tick++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (long_hold_go && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left   = $urandom_range(5, 40);
               ready_mode = $urandom_range(0, 3);
            end
            seg_left--;
            case (ready_mode)
               0: rsp_tready <= 1'b1;                         // no stalls
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (tick % 3) != 0;              // regular stall
               default: rsp_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: compare each result word with the oldest owed result
   // ---------------------------------------------------------------
   key_event_type got;
   key_event_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser[0];
         got.rel  = rsp_tuser[1];
         got.code = rsp_tdata[6:0];
         got.nrow = rsp_tdata[10:7];
         got.last = rsp_tlast;
         if (due_keys.size() == 0) begin
            $error("unexpected result word: kind %0d code %0d", got.kind, got.code);
            errors++;
         end else begin
            want = due_keys.pop_front();
            if (got.kind != want.kind) begin
               $error("item_kind: expected %0d, got %0d", want.kind, got.kind);
               errors++;
            end
            if (got.code != want.code) begin
               $error("key_code: expected %0d, got %0d", want.code, got.code);
               errors++;
            end
            if (got.rel != want.rel) begin
               $error("released: expected %0d, got %0d", want.rel, got.rel);
               errors++;
            end
            if (got.nrow != want.nrow) begin
               $error("next_row: expected %0d, got %0d", want.nrow, got.nrow);
               errors++;
            end
            if (got.last != want.last) begin
               $error("last: expected %0d, got %0d", want.last, got.last);
               errors++;
            end
            if (rsp_tdata[15:11] != '0) begin
               $error("tdata pad: expected 0, got %0h", rsp_tdata[15:11]);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: no handshake of any kind for too long
   // ---------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[key_matrix_scan_autorepeat] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus: a model keyboard whose rows are scanned in turn
   // ---------------------------------------------------------------
   logic [COLS-1:0]   held [NUM_ROWS];
   int                gen_row = 0;
   logic [CODE_W-1:0] gen_key = '0;

   // register write, only ever issued with the block idle
   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      if (idx == CSR_DELAY) begin
         rep_delay = val;
         rep_count = val;   // a new delay also restarts the count
      end else if (idx == CSR_PERIOD) begin
         rep_period = val;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_scan(input logic [COLS-1:0] cols);
      scan_word_type w;
      w.op   = OP_SCAN;
      w.cols = cols;
      w.key  = CODE_W'($urandom);   // unused on a scan word, kept noisy
      w.on   = 1'($urandom);
      held[gen_row] = cols;
      gen_row = (gen_row + 1) % NUM_ROWS;
      scan_words.push_back(w);
   endtask

   task automatic push_set(input logic [CODE_W-1:0] key, input logic on);
      scan_word_type w;
      w.op   = OP_SET;
      w.cols = COLS'($urandom);     // unused on a set-repeat word
      w.key  = key;
      w.on   = on;
      gen_key = key;
      scan_words.push_back(w);
   endtask

   task automatic push_random(input int count);
      int              sel;
      logic [COLS-1:0] cols;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 5) begin
            push_set(gen_key, 1'b1);          // often no change at all
         end else if (sel < 13) begin
            push_set(CODE_W'($urandom), ($urandom_range(0, 3) != 0));
         end else if (sel < 19) begin
            push_scan(COLS'($urandom));       // wild row, many events
         end else begin
            // realistic scan: a key or two goes down or comes up
            cols = held[gen_row];
            repeat ($urandom_range(0, 2)) cols[$urandom_range(0, COLS - 1)] ^= 1'b1;
            push_scan(cols);
         end
      end
   endtask

   // sender waits until every owed result is in, then lets the block settle
   task automatic drain();
      while (scan_words.size() != 0 || req_tvalid || due_keys.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      matrix_clear();
      foreach (held[r]) held[r] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: shortest delay and period so repeats show on every scan
      csr_write(CSR_DELAY, 16'd1);
      csr_write(CSR_PERIOD, 16'd1);
      push_set(7'd127, 1'b1);
      push_scan(8'hFF);               // repeat plus eight presses: ten results
      push_scan(8'h00);
      push_set(7'd127, 1'b1);         // same key, stays armed: no change
      push_set(7'd0, 1'b1);           // new key
      push_set(7'd55, 1'b0);          // disarm
      push_set(7'd55, 1'b0);          // disarm again: no change
      for (int r = 2; r < NUM_ROWS; r++)
         push_scan((r % 2) ? 8'h55 : 8'hAA);
      push_scan(8'h00);               // row wraps to 0: eight releases
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               csr_write(CSR_DELAY, 16'd3);
               csr_write(CSR_PERIOD, 16'd2);
            end
            1: begin
               csr_write(CSR_DELAY, 16'hFFFF);
               csr_write(CSR_PERIOD, 16'hFFFF);
            end
            2: begin
               csr_write(CSR_SPARE_A, 16'($urandom));
               csr_write(CSR_SPARE_B, 16'($urandom));
               csr_write(CSR_PERIOD, 16'd1);
               csr_write(CSR_DELAY, 16'd1);
               long_hold_go <= 1'b1;  // receiver backs off, sender keeps offering
            end
            3: begin
               csr_write(CSR_DELAY, 16'd0);   // count wraps, no repeat this phase
               csr_write(CSR_PERIOD, 16'($urandom_range(1, 6)));
            end
            default: begin
               csr_write(CSR_PERIOD, 16'($urandom_range(1, 4)));
               csr_write(CSR_DELAY, 16'($urandom_range(2, 9)));
            end
         endcase
         push_set(CODE_W'($urandom), 1'b1);
         push_random(PHASE_LEN - 1);
         drain();
      end

      if (errors == 0 && due_keys.size() == 0) begin
         $display("[key_matrix_scan_autorepeat] OK");
      end else begin
         $display("[key_matrix_scan_autorepeat] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/kms_pkg.sv
design/kms_ram.sv
design/kms_emit.sv
design/key_matrix_scan_autorepeat.sv
verif/testbench.sv
